[src/km3_pkg.sv]
package km3_pkg;

  localparam int NCL = 3;
  localparam int CW = 24;
  localparam int DW = 52;
  localparam int ACC_W = 64;
  localparam int PT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CFG = 2 * NCL;

  localparam int KM3_MAX_PASS_POINTS = 65535;
  localparam int KM3_FRAC_BITS = 8;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_CENT = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIST,
    S_DRAIN,
    S_ACC,
    S_EMIT_PT,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT_C
  } km3_state_t;

  typedef struct packed {
    logic       capture;
    logic       dist_en;
    logic [1:0] cl;
    logic       axis;
    logic [1:0] part;
    logic       acc;
    logic       emit_pt;
    logic       div_start;
    logic       div_wr;
    logic       emit_c;
  } km3_cmd_t;

  typedef struct packed {
    logic pend;
    logic div_done;
    logic div_skip;
  } km3_sts_t;

endpackage

[src/kmeans_three_cluster_2d.sv]
// path from the accepting edge to the assignment word: 24 squaring steps, a drain,
// an accumulate and the output register; the next word is taken once busy falls;
// pass end adds up to six serial divides of sum_w+frac_bits quotient bits each (a
// divide is skipped for an empty cluster or an overflowed pass), then three centroid
// words on consecutive cycles; one point at a time
// rst is synchronous and clears centroids, sums, counts and the config
// registers; the receiver cannot stall, each word is valid for one cycle
module kmeans_three_cluster_2d import km3_pkg::*; #(
  parameter int MAX_PASS_POINTS = KM3_MAX_PASS_POINTS,
  parameter int FRAC_BITS = KM3_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PT_W-1:0]      point_x,
  input  logic [PT_W-1:0]      point_y,
  input  logic                 load_start,
  input  logic                 pass_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_data,
  output logic                 result_valid,
  output logic                 result_kind,
  output logic [1:0]           cluster_id,
  output logic [DW-1:0]        distance_sq,
  output logic [CW-1:0]        centroid_x,
  output logic [CW-1:0]        centroid_y,
  output logic                 overflow,
  output logic                 last
);

  km3_cmd_t cmd;
  km3_sts_t sts;

  km3_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  km3_dp #(
    .MAX_PASS_POINTS (MAX_PASS_POINTS),
    .FRAC_BITS       (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point_x      (point_x),
    .point_y      (point_y),
    .load_start   (load_start),
    .pass_end     (pass_end),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .cluster_id   (cluster_id),
    .distance_sq  (distance_sq),
    .centroid_x   (centroid_x),
    .centroid_y   (centroid_y),
    .overflow     (overflow),
    .last         (last)
  );

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> cluster_id != 2'd0)
    else $error("result word with cluster id zero");

  a_cent_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_CENT) && !last |=>
      result_valid && (result_kind == KIND_CENT))
    else $error("centroid report burst broken");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("word right after the last word");
`endif

endmodule

[src/km3_div.sv]
module km3_div import km3_pkg::*; #(
  parameter int NW = 33,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NW-1:0]    num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NW-1:0]    quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W+1:0] trial;

  // one quotient bit a cycle, restoring
  assign trial = {rem, quo[NW-1]} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (cnt != '0) begin
      if (!trial[DEN_W+1]) begin
        rem <= trial[DEN_W:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_W-1:0], quo[NW-1]};
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

[src/km3_ctrl.sv]
module km3_ctrl import km3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  km3_sts_t sts,
  output logic     busy,
  output km3_cmd_t cmd
);

  km3_state_t state, state_next;
  logic [1:0] cl, cl_next;
  logic       axis, axis_next;
  logic [1:0] part, part_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cl    <= '0;
      axis  <= AXIS_X;
      part  <= '0;
    end else begin
      state <= state_next;
      cl    <= cl_next;
      axis  <= axis_next;
      part  <= part_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cl_next       = cl;
    axis_next     = axis;
    part_next     = part;
    cmd           = '0;
    cmd.cl        = cl;
    cmd.axis      = axis;
    cmd.part      = part;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          cl_next     = '0;
          axis_next   = AXIS_X;
          part_next   = '0;
          state_next  = S_DIST;
        end
      end
      S_DIST: begin
        cmd.dist_en = 1'b1;
        part_next   = part + 1'b1;
        if (part == 2'd3) begin
          axis_next = ~axis;
          if (axis == AXIS_Y) begin
            cl_next = cl + 1'b1;
            if (cl == 2'(NCL - 1)) begin
              state_next = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_EMIT_PT;
      end
      S_EMIT_PT: begin
        cmd.emit_pt = 1'b1;
        cl_next     = '0;
        axis_next   = AXIS_X;
        state_next  = sts.pend ? S_DIV_START : S_IDLE;
      end
      S_DIV_START: begin
        if (sts.div_skip) begin
          axis_next = ~axis;
          if (axis == AXIS_Y) begin
            cl_next = cl + 1'b1;
            if (cl == 2'(NCL - 1)) begin
              cl_next    = '0;
              state_next = S_EMIT_C;
            end
          end
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_wr = 1'b1;
          axis_next  = ~axis;
          state_next = S_DIV_START;
          if (axis == AXIS_Y) begin
            cl_next = cl + 1'b1;
            if (cl == 2'(NCL - 1)) begin
              cl_next    = '0;
              state_next = S_EMIT_C;
            end
          end
        end
      end
      S_EMIT_C: begin
        cmd.emit_c = 1'b1;
        cl_next    = cl + 1'b1;
        if (cl == 2'(NCL - 1)) begin
          cl_next    = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/km3_dp.sv]
module km3_dp import km3_pkg::*; #(
  parameter int MAX_PASS_POINTS = KM3_MAX_PASS_POINTS,
  parameter int FRAC_BITS = KM3_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  km3_cmd_t             cmd,
  output km3_sts_t             sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_data,
  input  logic [PT_W-1:0]      point_x,
  input  logic [PT_W-1:0]      point_y,
  input  logic                 load_start,
  input  logic                 pass_end,
  output logic                 result_valid,
  output logic                 result_kind,
  output logic [1:0]           cluster_id,
  output logic [DW-1:0]        distance_sq,
  output logic [CW-1:0]        centroid_x,
  output logic [CW-1:0]        centroid_y,
  output logic                 overflow,
  output logic                 last
);

  localparam int CNT_W = $clog2(MAX_PASS_POINTS + 2);
  localparam int SUM_W = PT_W + CNT_W;
  localparam int NW = SUM_W + FRAC_BITS;
  localparam int QW = (NW > CW + 1) ? NW : CW + 1;
  localparam int AW = ((PT_W + FRAC_BITS > CW) ? PT_W + FRAC_BITS : CW) + 1;
  localparam int H = (AW + 1) / 2;

  logic signed [CW-1:0]    init_c [NUM_CFG];
  logic signed [CW-1:0]    cent_x [NCL];
  logic signed [CW-1:0]    cent_y [NCL];
  logic signed [SUM_W-1:0] sum_x [NCL];
  logic signed [SUM_W-1:0] sum_y [NCL];
  logic [CNT_W-1:0]        member_count [NCL];
  logic [CNT_W-1:0]        pass_points;
  logic [CNT_W-1:0]        pass_points_next;
  logic                    ovf;

  logic signed [PT_W-1:0]  px, py;
  logic                    pend;

  // distance pipeline
  logic signed [CW-1:0]    cent_sel;
  logic signed [PT_W-1:0]  pt_sel;
  logic signed [AW-1:0]    pt_w, pt_sh, diff;
  logic [AW-1:0]           mag;
  logic [2*H-1:0]          magp;
  logic [H-1:0]            opa, opb;
  logic [2*H-1:0]          prod, prod_r;
  logic                    pp_v, pp_first, pp_fin;
  logic [1:0]              pp_part, pp_cl;
  logic [ACC_W-1:0]        term, dsum, dacc, best_d;
  logic [1:0]              best;

  // divide
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic                    div_neg;
  logic                    div_done;
  logic [NW-1:0]           quo;
  logic [QW-1:0]           qx;
  logic signed [CW-1:0]    mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        init_c[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
      init_c[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px   <= point_x;
      py   <= point_y;
      pend <= pass_end;
    end
  end

  assign cent_sel = (cmd.axis == AXIS_Y) ? cent_y[cmd.cl] : cent_x[cmd.cl];
  assign pt_sel   = (cmd.axis == AXIS_Y) ? py : px;
  assign pt_w     = AW'(pt_sel);
  assign pt_sh    = pt_w <<< FRAC_BITS;
  assign diff     = pt_sh - AW'(cent_sel);
  assign mag      = diff[AW-1] ? AW'(-diff) : AW'(diff);
  assign magp     = (2*H)'(mag);

  // square as four half-width partial products
  always_comb begin
    case (cmd.part)
      2'd0:    begin opa = magp[H-1:0];   opb = magp[H-1:0];   end
      2'd1:    begin opa = magp[H-1:0];   opb = magp[2*H-1:H]; end
      2'd2:    begin opa = magp[2*H-1:H]; opb = magp[H-1:0];   end
      default: begin opa = magp[2*H-1:H]; opb = magp[2*H-1:H]; end
    endcase
  end

  assign prod = opa * opb;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_v <= 1'b0;
    end else begin
      pp_v <= cmd.dist_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod;
    pp_part  <= cmd.part;
    pp_cl    <= cmd.cl;
    pp_first <= (cmd.axis == AXIS_X) && (cmd.part == 2'd0);
    pp_fin   <= (cmd.axis == AXIS_Y) && (cmd.part == 2'd3);
  end

  always_comb begin
    case (pp_part)
      2'd0:    term = ACC_W'(prod_r);
      2'd3:    term = ACC_W'(prod_r) << (2 * H);
      default: term = ACC_W'(prod_r) << H;
    endcase
  end

  assign dsum = (pp_first ? '0 : dacc) + term;

  always_ff @(posedge clk) begin
    if (pp_v) begin
      dacc <= dsum;
      // later cluster wins a tie
      if (pp_fin && ((pp_cl == 2'd0) || (dsum <= best_d))) begin
        best_d <= dsum;
        best   <= pp_cl;
      end
    end
  end

  always_comb begin
    pass_points_next = pass_points;
    if (pass_points <= CNT_W'(MAX_PASS_POINTS)) begin
      pass_points_next = pass_points + 1'b1;
    end
  end

  assign sum_sel = (cmd.axis == AXIS_Y) ? sum_y[cmd.cl] : sum_x[cmd.cl];
  assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

  km3_div #(
    .NW    (NW),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({sum_mag, FRAC_BITS'(0)} ),
    .den   (member_count[cmd.cl]),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= sum_sel[SUM_W-1];
    end
  end

  // signed mean, saturated to the centroid width
  assign qx = QW'(quo);
  always_comb begin
    if (div_neg) begin
      if (qx > QW'(2 ** (CW - 1))) begin
        mean = {1'b1, {(CW-1){1'b0}}};
      end else begin
        mean = CW'(-qx);
      end
    end else begin
      if (qx > QW'(2 ** (CW - 1) - 1)) begin
        mean = {1'b0, {(CW-1){1'b1}}};
      end else begin
        mean = CW'(qx);
      end
    end
  end

  assign sts.pend     = pend;
  assign sts.div_done = div_done;
  assign sts.div_skip = ovf || (member_count[cmd.cl] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NCL; k++) begin
        cent_x[k]       <= '0;
        cent_y[k]       <= '0;
        sum_x[k]        <= '0;
        sum_y[k]        <= '0;
        member_count[k] <= '0;
      end
      pass_points <= '0;
      ovf         <= 1'b0;
    end else begin
      if (cmd.capture && load_start) begin
        for (int k = 0; k < NCL; k++) begin
          cent_x[k]       <= init_c[2*k];
          cent_y[k]       <= init_c[2*k+1];
          sum_x[k]        <= '0;
          sum_y[k]        <= '0;
          member_count[k] <= '0;
        end
        pass_points <= '0;
      end
      if (cmd.acc) begin
        pass_points <= pass_points_next;
        ovf         <= (pass_points_next > CNT_W'(MAX_PASS_POINTS));
        if (!(pass_points_next > CNT_W'(MAX_PASS_POINTS))) begin
          sum_x[best]        <= sum_x[best] + SUM_W'(px);
          sum_y[best]        <= sum_y[best] + SUM_W'(py);
          member_count[best] <= member_count[best] + 1'b1;
        end
      end
      if (cmd.div_wr) begin
        if (cmd.axis == AXIS_Y) begin
          cent_y[cmd.cl] <= mean;
        end else begin
          cent_x[cmd.cl] <= mean;
        end
      end
      // pass end clears after the last report
      if (cmd.emit_c && (cmd.cl == 2'(NCL - 1))) begin
        for (int k = 0; k < NCL; k++) begin
          sum_x[k]        <= '0;
          sum_y[k]        <= '0;
          member_count[k] <= '0;
        end
        pass_points <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_pt || cmd.emit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pt) begin
      result_kind <= KIND_POINT;
      cluster_id  <= best + 1'b1;
      distance_sq <= best_d[DW-1:0];
      centroid_x  <= '0;
      centroid_y  <= '0;
      overflow    <= ovf;
      last        <= !pend;
    end else if (cmd.emit_c) begin
      result_kind <= KIND_CENT;
      cluster_id  <= cmd.cl + 1'b1;
      distance_sq <= '0;
      centroid_x  <= cent_x[cmd.cl];
      centroid_y  <= cent_y[cmd.cl];
      overflow    <= ovf;
      last        <= (cmd.cl == 2'(NCL - 1));
    end
  end

endmodule

[bench/tb_kmeans_three_cluster_2d.sv]
`timescale 1ns / 1ps

module tb_kmeans_three_cluster_2d;
  import km3_pkg::*;

  localparam int N_RANDOM = 150;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [PT_W-1:0] px;
    logic [PT_W-1:0] py;
    logic            load;
    logic            pend;
  } point_word_t;

  typedef struct packed {
    logic          kind;
    logic [1:0]    cl;
    logic [DW-1:0] dsq;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic          ovf;
    logic          lst;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [PT_W-1:0] point_x = '0;
  logic [PT_W-1:0] point_y = '0;
  logic load_start = 1'b0;
  logic pass_end = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic result_valid;
  logic result_kind;
  logic [1:0] cluster_id;
  logic [DW-1:0] distance_sq;
  logic [CW-1:0] centroid_x;
  logic [CW-1:0] centroid_y;
  logic overflow;
  logic last;

  kmeans_three_cluster_2d i_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  longint init_cent [NUM_CFG];
  longint cent_x [NCL];
  longint cent_y [NCL];
  longint sum_x [NCL];
  longint sum_y [NCL];
  int     members [NCL];
  int     pass_points;

  point_word_t  pending_points [$];
  result_word_t expected_results [$];
  int  errors = 0;
  int  gap_left = 0;
  bit  hold_sender = 1'b0;
  longint cycles = 0;

  function automatic longint sat_cent(longint v);
    longint hi = (64'sd1 <<< (CW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint mean_fixed(longint s, int n);
    longint q;
    q = ((s < 0 ? -s : s) <<< KM3_FRAC_BITS) / n;
    return s < 0 ? -q : q;
  endfunction

  function automatic void clear_pass();
    for (int k = 0; k < NCL; k++) begin
      sum_x[k] = 0;
      sum_y[k] = 0;
      members[k] = 0;
    end
    pass_points = 0;
  endfunction

  function automatic void predict_assignment(point_word_t p);
    longint px, py, dx, dy;
    logic [63:0] d, best_d;
    int best;
    bit ovf;
    result_word_t r;
    px = longint'($signed(p.px)) <<< KM3_FRAC_BITS;
    py = longint'($signed(p.py)) <<< KM3_FRAC_BITS;
    best_d = '0;
    best = 0;
    if (p.load) begin
      for (int k = 0; k < NCL; k++) begin
        cent_x[k] = init_cent[2 * k];
        cent_y[k] = init_cent[2 * k + 1];
      end
      clear_pass();
    end
    for (int k = 0; k < NCL; k++) begin
      dx = px - cent_x[k];
      dy = py - cent_y[k];
      d = dx * dx + dy * dy;
      // ties go to the higher cluster
      if (k == 0 || d <= best_d) begin
        best_d = d;
        best = k;
      end
    end
    if (pass_points <= KM3_MAX_PASS_POINTS) pass_points++;
    ovf = pass_points > KM3_MAX_PASS_POINTS;
    if (!ovf) begin
      sum_x[best] += longint'($signed(p.px));
      sum_y[best] += longint'($signed(p.py));
      members[best]++;
    end
    r = '{KIND_POINT, 2'(best + 1), best_d[DW-1:0], '0, '0, ovf, !p.pend};
    expected_results.insert(expected_results.size(), r);
    if (p.pend) begin
      for (int k = 0; k < NCL; k++) begin
        if (!ovf && members[k] != 0) begin
          cent_x[k] = sat_cent(mean_fixed(sum_x[k], members[k]));
          cent_y[k] = sat_cent(mean_fixed(sum_y[k], members[k]));
        end
        r = '{KIND_CENT, 2'(k + 1), '0, cent_x[k][CW-1:0], cent_y[k][CW-1:0],
              ovf, k == NCL - 1};
        expected_results.insert(expected_results.size(), r);
      end
      clear_pass();
    end
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_assignment('{point_x, point_y, load_start, pass_end});
      end
      if (start && busy) begin
        // hold the word until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_points.size() > 0 && !hold_sender) begin
        point_word_t p;
        p = pending_points.pop_front();
        point_x <= p.px;
        point_y <= p.py;
        load_start <= p.load;
        pass_end <= p.pend;
        start <= 1'b1;
        if ($urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 40);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      result_word_t got, want;
      got = '{result_kind, cluster_id, distance_sq, centroid_x, centroid_y,
              overflow, last};
      if (expected_results.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected kind=%0d cl=%0d d=%h cx=%h cy=%h ovf=%0d last=%0d",
                   $time, want.kind, want.cl, want.dsq, want.cx, want.cy, want.ovf,
                   want.lst);
          $display("%0t          actual   kind=%0d cl=%0d d=%h cx=%h cy=%h ovf=%0d last=%0d",
                   $time, got.kind, got.cl, got.dsq, got.cx, got.cy, got.ovf, got.lst);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_point(int x, int y, bit ld, bit pe);
    point_word_t p;
    p = '{PT_W'(x), PT_W'(y), ld, pe};
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic write_reg(int idx, logic [CW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= v;
    if (idx < NUM_CFG) init_cent[idx] = longint'($signed(v));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // checked away from the rising edge so the driver's updates have settled
  task automatic wait_drained();
    while (pending_points.size() > 0 || expected_results.size() > 0 || start || busy)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic int rand_coord(bit wide);
    if (wide) return $urandom_range(0, 65535);
    return int'($urandom_range(0, 400)) - 200;
  endfunction

  initial begin
    for (int i = 0; i < NUM_CFG; i++) init_cent[i] = 0;
    for (int k = 0; k < NCL; k++) begin
      cent_x[k] = 0;
      cent_y[k] = 0;
    end
    clear_pass();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset centroids, all zero, ties to cluster 3
    push_point(0, 0, 0, 0);
    push_point(32767, -32768, 0, 0);
    push_point(-32768, 32767, 0, 0);
    push_point(-32768, -32768, 0, 1);
    wait_drained();

    // extreme init centroids, out-of-range index ignored
    write_reg(0, 24'h7fffff);
    write_reg(1, 24'h800000);
    write_reg(2, 24'h800000);
    write_reg(3, 24'h7fffff);
    write_reg(4, 24'h000100);
    write_reg(5, 24'hffff00);
    write_reg(6, 24'h123456);
    write_reg(7, 24'h654321);
    push_point(32767, -32768, 1, 0);
    push_point(-32768, 32767, 0, 0);
    push_point(32767, 32767, 0, 0);
    push_point(1, -1, 0, 0);
    push_point(-32768, -32768, 0, 1);
    // empty clusters keep their centroids
    push_point(100, 100, 1, 1);
    push_point(-5, 7, 0, 0);
    push_point(-6, 8, 0, 1);
    wait_drained();

    // random phases with fresh centroids
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NUM_CFG; i++)
        write_reg(i, (ph == 5) ? CW'($urandom) : CW'((int'($urandom_range(0, 400)) - 200) * 256));
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        bit wide;
        wide = ($urandom_range(0, 4) == 0);
        push_point(rand_coord(wide), rand_coord(wide), n == 0 || $urandom_range(0, 30) == 0,
                   $urandom_range(0, 7) == 0);
      end
      push_point(rand_coord(0), rand_coord(0), 0, 1);
      if (ph == 2) begin
        // sender holds off until everything is back
        while (pending_points.size() > 0) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() > 0 || start) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
src/km3_pkg.sv
src/km3_div.sv
src/km3_ctrl.sv
src/km3_dp.sv
src/kmeans_three_cluster_2d.sv
bench/tb_kmeans_three_cluster_2d.sv
